>>> rtl/sfra_pkg.sv
package sfra_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int PTR_W      = IDX_W + 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int PAGE_W     = 20;
  localparam int LEN_W      = PAGE_W + 1;
  localparam int NCLASS     = PAGE_W + 1;
  localparam int CLS_W      = $clog2(NCLASS + 1);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_RANGES);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTALLOC = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_PAGES = 1'b1;

  // clipped heap window
  typedef struct packed {
    logic [PAGE_W-1:0] base;
    logic [LEN_W-1:0]  pages;
  } win_t;

  // size class of a length: floor(log2)
  function automatic logic [CLS_W-1:0] size_class(input logic [LEN_W-1:0] v);
    logic [CLS_W-1:0] r;
    r = '0;
    for (int k = 1; k < LEN_W; k++) begin
      if (v[k]) r = CLS_W'(k);
    end
    return r;
  endfunction

endpackage

>>> rtl/sfra_ram.sv
module sfra_ram #(
  parameter int W  = 8,
  parameter int D  = 64,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sfra_ctrl.sv
module sfra_ctrl
  import sfra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              init_req,
  input  win_t              win,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [LEN_W-1:0]  req_pages,
  input  logic [PAGE_W-1:0] req_page,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [PAGE_W-1:0] granted_page
);

  typedef enum logic [18:0] {
    S_INIT    = 19'h00001,
    S_IDLE    = 19'h00002,
    S_A_START = 19'h00004,
    S_A_CLS   = 19'h00008,
    S_A_CHK   = 19'h00010,
    S_A_SPLIT = 19'h00020,
    S_A_POP   = 19'h00040,
    S_A_LNK   = 19'h00080,
    S_F_SCAN  = 19'h00100,
    S_F_NX    = 19'h00200,
    S_F_PV    = 19'h00400,
    S_F_XR    = 19'h00800,
    S_U_START = 19'h01000,
    S_U_WALK  = 19'h02000,
    S_REL     = 19'h04000,
    S_F_APP   = 19'h08000,
    S_FIN     = 19'h10000,
    S_SPARE0  = 19'h20000,
    S_SPARE1  = 19'h40000
  } state_t;

  state_t st;

  logic [LEN_W-1:0]  size;
  logic [PAGE_W-1:0] addr;
  logic [CLS_W-1:0]  cls, uc;
  logic [PTR_W-1:0]  q, p, e, s, x, enext, eprev, rel_n;
  logic              mdir;
  logic [PAGE_W-1:0] estart;
  logic [LEN_W-1:0]  elen;
  logic [CNT_W-1:0]  i;
  logic              chkv;
  logic [IDX_W-1:0]  ci;
  logic [2:0]        res_status;
  logic [PAGE_W-1:0] res_granted;

  logic [PTR_W-1:0]  head [NCLASS];
  logic [PTR_W-1:0]  tail [NCLASS];
  logic [NCLASS-1:0] cmap;
  logic [MAX_RANGES-1:0] flags_v, flags_a, swr;
  logic [CNT_W-1:0]  count;
  logic              stk_hit_r;
  logic [IDX_W-1:0]  stk_def_r;

  // shared read address for all entry memories but the spare stack
  logic [IDX_W-1:0]  ra;
  logic [PAGE_W-1:0] rd_start;
  logic [LEN_W-1:0]  rd_len;
  logic [PTR_W-1:0]  rd_prev, rd_next, rd_cn;
  logic [IDX_W-1:0]  rd_stk;

  logic              start_we, len_we, prev_we, next_we, cn_we, stk_we;
  logic [IDX_W-1:0]  start_wa, len_wa, prev_wa, next_wa, cn_wa, stk_wa, stk_ra;
  logic [PAGE_W-1:0] start_wd;
  logic [LEN_W-1:0]  len_wd;
  logic [PTR_W-1:0]  prev_wd, next_wd, cn_wd;
  logic [IDX_W-1:0]  stk_wd;

  logic              un_en, ap_en;
  logic [CLS_W-1:0]  un_c, ap_c, cls_ix, cur_c, a_c0, init_c;
  logic [PTR_W-1:0]  un_p, un_x, un_nx, ap_e, nq;
  logic [IDX_W-1:0]  s_val;
  logic              fit, hit, nx_free, pv_free;

  assign cls_ix  = (cls < CLS_W'(NCLASS)) ? cls : '0;
  assign cur_c   = (st == S_U_WALK) ? uc : cls_ix;
  assign nq      = (q == tail[cur_c]) ? NIL : rd_cn;
  assign fit     = rd_len >= size;
  assign hit     = chkv && flags_v[ci] && flags_a[ci] && (rd_start == addr);
  assign s_val   = stk_hit_r ? rd_stk : stk_def_r;
  assign a_c0    = size_class(size);
  assign init_c  = size_class(win.pages);
  assign nx_free = (enext != NIL) && flags_v[enext[IDX_W-1:0]] && !flags_a[enext[IDX_W-1:0]];
  assign pv_free = (eprev != NIL) && flags_v[eprev[IDX_W-1:0]] && !flags_a[eprev[IDX_W-1:0]];
  assign stk_ra  = IDX_W'(count - CNT_W'(1));
  assign in_ready = (st == S_IDLE) && !init_req;

  always_comb begin
    ra = '0;
    un_en = 1'b0; un_c = '0; un_p = NIL; un_x = NIL; un_nx = NIL;
    ap_en = 1'b0; ap_c = '0; ap_e = NIL;
    start_we = 1'b0; start_wa = '0; start_wd = '0;
    len_we = 1'b0; len_wa = '0; len_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = NIL;
    next_we = 1'b0; next_wa = '0; next_wd = NIL;
    stk_we = 1'b0; stk_wa = count[IDX_W-1:0]; stk_wd = x[IDX_W-1:0];
    unique case (st)
      S_INIT: begin
        start_we = 1'b1; start_wd = win.base;
        len_we = 1'b1; len_wd = win.pages;
        prev_we = 1'b1; next_we = 1'b1;
      end
      S_A_CLS: ra = head[cls_ix][IDX_W-1:0];
      S_A_CHK: begin
        if (fit) begin
          un_en = 1'b1; un_c = cls_ix; un_p = p; un_x = q; un_nx = nq;
        end else begin
          ra = nq[IDX_W-1:0];
        end
      end
      S_A_SPLIT: begin
        if (elen > size && count == '0) begin
          ap_en = 1'b1; ap_c = size_class(elen); ap_e = e;
        end
      end
      S_A_POP: begin
        start_we = 1'b1; start_wa = s_val; start_wd = estart + size[PAGE_W-1:0];
        len_we = 1'b1; len_wa = s_val; len_wd = elen - size;
        prev_we = 1'b1; prev_wa = s_val; prev_wd = e;
        next_we = 1'b1; next_wa = s_val; next_wd = enext;
      end
      S_A_LNK: begin
        prev_we = (enext != NIL); prev_wa = enext[IDX_W-1:0]; prev_wd = s;
        next_we = 1'b1; next_wa = e[IDX_W-1:0]; next_wd = s;
        len_we = 1'b1; len_wa = e[IDX_W-1:0]; len_wd = size;
        ap_en = 1'b1; ap_c = size_class(elen - size); ap_e = s;
      end
      S_F_SCAN: ra = i[IDX_W-1:0];
      S_F_NX:   ra = enext[IDX_W-1:0];
      S_F_PV:   ra = eprev[IDX_W-1:0];
      S_U_START: ra = head[uc][IDX_W-1:0];
      S_U_WALK: begin
        if (q == x) begin
          un_en = 1'b1; un_c = uc; un_p = p; un_x = x; un_nx = nq;
        end else begin
          ra = nq[IDX_W-1:0];
        end
      end
      S_REL: begin
        stk_we = (count < CNT_W'(MAX_RANGES));
        if (!mdir) begin
          next_we = 1'b1; next_wa = e[IDX_W-1:0]; next_wd = rel_n;
          prev_we = (rel_n != NIL); prev_wa = rel_n[IDX_W-1:0]; prev_wd = e;
        end else begin
          prev_we = 1'b1; prev_wa = e[IDX_W-1:0]; prev_wd = rel_n;
          next_we = (rel_n != NIL); next_wa = rel_n[IDX_W-1:0]; next_wd = e;
        end
      end
      S_F_APP: begin
        start_we = 1'b1; start_wa = e[IDX_W-1:0]; start_wd = estart;
        len_we = 1'b1; len_wa = e[IDX_W-1:0]; len_wd = elen;
        ap_en = 1'b1; ap_c = size_class(elen); ap_e = e;
      end
      default: ;
    endcase
    // class chain link writes come from unlink or append
    cn_we = 1'b0; cn_wa = '0; cn_wd = NIL;
    if (un_en && un_p != NIL) begin
      cn_we = 1'b1; cn_wa = un_p[IDX_W-1:0]; cn_wd = un_nx;
    end else if (ap_en && cmap[ap_c]) begin
      cn_we = 1'b1; cn_wa = tail[ap_c][IDX_W-1:0]; cn_wd = ap_e;
    end
  end

  sfra_ram #(.W(PAGE_W), .D(MAX_RANGES)) u_start (
    .clk, .we(start_we), .waddr(start_wa), .wdata(start_wd), .raddr(ra), .rdata(rd_start));
  sfra_ram #(.W(LEN_W), .D(MAX_RANGES)) u_len (
    .clk, .we(len_we), .waddr(len_wa), .wdata(len_wd), .raddr(ra), .rdata(rd_len));
  sfra_ram #(.W(PTR_W), .D(MAX_RANGES)) u_prev (
    .clk, .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(ra), .rdata(rd_prev));
  sfra_ram #(.W(PTR_W), .D(MAX_RANGES)) u_next (
    .clk, .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(ra), .rdata(rd_next));
  sfra_ram #(.W(PTR_W), .D(MAX_RANGES)) u_cnext (
    .clk, .we(cn_we), .waddr(cn_wa), .wdata(cn_wd), .raddr(ra), .rdata(rd_cn));
  sfra_ram #(.W(IDX_W), .D(MAX_RANGES)) u_stack (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(rd_stk));

  always_ff @(posedge clk) begin
    stk_hit_r <= swr[stk_ra];
    stk_def_r <= IDX_W'(CNT_W'(MAX_RANGES) - count);
    if (rst) begin
      st <= S_INIT;
      out_valid <= 1'b0;
      flags_v <= '0;
      flags_a <= '0;
      swr <= '0;
      cmap <= '0;
      count <= '0;
      chkv <= 1'b0;
    end else begin
      if (out_valid && out_ready && st != S_FIN) out_valid <= 1'b0;
      if (un_en) begin
        if (un_p == NIL) head[un_c] <= un_nx;
        if (tail[un_c] == un_x) tail[un_c] <= un_p;
        if (un_p == NIL && un_nx == NIL) cmap[un_c] <= 1'b0;
      end
      if (ap_en) begin
        if (!cmap[ap_c]) head[ap_c] <= ap_e;
        tail[ap_c] <= ap_e;
        cmap[ap_c] <= 1'b1;
      end
      if (stk_we) begin
        swr[count[IDX_W-1:0]] <= 1'b1;
        count <= count + CNT_W'(1);
      end
      if (init_req) begin
        st <= S_INIT;
      end else unique case (st)
        S_INIT: begin
          flags_v <= MAX_RANGES'(1);
          flags_a <= '0;
          swr <= '0;
          count <= CNT_W'(MAX_RANGES - 1);
          cmap <= NCLASS'(1) << init_c;
          head[init_c] <= '0;
          tail[init_c] <= '0;
          st <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            size <= req_pages;
            addr <= req_page;
            res_granted <= '0;
            i <= '0;
            chkv <= 1'b0;
            st <= (cmd == CMD_ALLOC) ? S_A_START : S_F_SCAN;
          end
        end
        S_A_START: begin
          if (size == '0) begin
            res_status <= ST_NOFIT;
            st <= S_FIN;
          end else begin
            // not a power of two: try one class up when any class above has entries
            if ((size & (size - LEN_W'(1))) != '0 && (cmap >> (a_c0 + CLS_W'(1))) != '0)
              cls <= a_c0 + CLS_W'(1);
            else
              cls <= a_c0;
            st <= S_A_CLS;
          end
        end
        S_A_CLS: begin
          if (cls >= CLS_W'(NCLASS)) begin
            res_status <= ST_NOFIT;
            st <= S_FIN;
          end else if (!cmap[cls_ix]) begin
            cls <= cls + CLS_W'(1);
          end else begin
            q <= head[cls_ix];
            p <= NIL;
            st <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (fit) begin
            e <= q;
            estart <= rd_start;
            elen <= rd_len;
            enext <= rd_next;
            st <= S_A_SPLIT;
          end else if (nq == NIL) begin
            cls <= cls + CLS_W'(1);
            st <= S_A_CLS;
          end else begin
            p <= q;
            q <= nq;
          end
        end
        S_A_SPLIT: begin
          if (elen > size) begin
            if (count == '0) begin
              res_status <= ST_FULL;
              st <= S_FIN;
            end else begin
              st <= S_A_POP;
            end
          end else begin
            flags_a[e[IDX_W-1:0]] <= 1'b1;
            res_status <= ST_OK;
            res_granted <= estart;
            st <= S_FIN;
          end
        end
        S_A_POP: begin
          s <= {1'b0, s_val};
          count <= count - CNT_W'(1);
          flags_v[s_val] <= 1'b1;
          flags_a[s_val] <= 1'b0;
          st <= S_A_LNK;
        end
        S_A_LNK: begin
          flags_a[e[IDX_W-1:0]] <= 1'b1;
          res_status <= ST_OK;
          res_granted <= estart;
          st <= S_FIN;
        end
        S_F_SCAN: begin
          if (hit) begin
            e <= {1'b0, ci};
            if (rd_len != size) begin
              res_status <= ST_MISMATCH;
              st <= S_FIN;
            end else begin
              flags_a[ci] <= 1'b0;
              estart <= rd_start;
              elen <= rd_len;
              enext <= rd_next;
              eprev <= rd_prev;
              st <= S_F_NX;
            end
          end else if (i == CNT_W'(MAX_RANGES)) begin
            res_status <= ST_NOTALLOC;
            st <= S_FIN;
          end else begin
            ci <= i[IDX_W-1:0];
            chkv <= 1'b1;
            i <= i + CNT_W'(1);
          end
        end
        S_F_NX: begin
          if (nx_free) begin
            x <= enext;
            mdir <= 1'b0;
            st <= S_F_XR;
          end else begin
            st <= S_F_PV;
          end
        end
        S_F_PV: begin
          if (pv_free) begin
            x <= eprev;
            mdir <= 1'b1;
            st <= S_F_XR;
          end else begin
            st <= S_F_APP;
          end
        end
        S_F_XR: begin
          elen <= elen + rd_len;
          if (mdir) estart <= rd_start;
          rel_n <= mdir ? rd_prev : rd_next;
          uc <= size_class(rd_len);
          st <= S_U_START;
        end
        S_U_START: begin
          q <= head[uc];
          p <= NIL;
          st <= S_U_WALK;
        end
        S_U_WALK: begin
          if (q == x || nq == NIL) begin
            st <= S_REL;
          end else begin
            p <= q;
            q <= nq;
          end
        end
        S_REL: begin
          flags_v[x[IDX_W-1:0]] <= 1'b0;
          flags_a[x[IDX_W-1:0]] <= 1'b0;
          st <= mdir ? S_F_APP : S_F_PV;
        end
        S_F_APP: begin
          res_status <= ST_OK;
          st <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= res_status;
            granted_page <= res_granted;
            st <= S_IDLE;
          end
        end
        default: st <= S_INIT;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(st))
    else $error("sequencer state not one-hot");
  a_alloc_implies_valid: assert property (@(posedge clk) disable iff (rst)
    (flags_a & ~flags_v) == '0)
    else $error("allocated flag on an invalid entry");
  a_spare_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RANGES))
    else $error("spare entry count overflow");
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (st == S_FIN && res_status != ST_OK) |-> res_granted == '0)
    else $error("granted page on a failed request");
`endif

endmodule

>>> rtl/segregated_fit_range_allocator.sv
// alloc: picks a size class, walks the class chains from there upward to the first entry that
//   fits, and on a larger entry splits off the rest into a spare entry; an exact fit is not split
// free: scans the entries for an allocated range that starts at the page, then merges it with a
//   free next and a free previous neighbour, unlinking each from its class chain
// throughput: one request at a time, set by the walk over the shared entry memories
// reset (and any register write) rebuilds the table as one free range
module segregated_fit_range_allocator
  import sfra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [LEN_W-1:0]  cfg_data,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [LEN_W-1:0]  req_pages,
  input  logic [PAGE_W-1:0] req_page,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [PAGE_W-1:0] granted_page
);

  // window registers
  logic [PAGE_W-1:0] base_r;
  logic [LEN_W-1:0]  pages_r;
  logic [LEN_W-1:0]  room, pages_nz;
  win_t              win;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_r  <= '0;
      pages_r <= LEN_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index[0])
        REG_BASE:  base_r  <= cfg_data[PAGE_W-1:0];
        REG_PAGES: pages_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clip the page count to what is left above the base, zero counts as one
  assign room     = (LEN_W'(1) << PAGE_W) - {1'b0, base_r};
  assign pages_nz = (pages_r == '0) ? LEN_W'(1) : pages_r;
  assign win.base  = base_r;
  assign win.pages = (pages_nz > room) ? room : pages_nz;

  // a register write rebuilds the table from the new window
  sfra_ctrl u_ctrl (
    .clk,
    .rst,
    .init_req(cfg_we),
    .win,
    .in_valid,
    .in_ready,
    .cmd,
    .req_pages,
    .req_page,
    .out_valid,
    .out_ready,
    .status,
    .granted_page
  );

endmodule
